@@ design/ntt_bfly_pkg.sv @@
// Shared types and constants of the Stockham NTT butterfly core.
// Used by the queue front, the butterfly back end, the top level and the checker.
package ntt_bfly_pkg;

    localparam int VALUE_BITS        = 12;
    localparam int ADDR_BITS         = 12;
    localparam int SPAN_BITS         = 12;
    localparam int PAIR_BITS         = 11;
    localparam int FACTOR_BITS       = 52;
    localparam int BARRETT_SHIFT     = 52;
    localparam int BARRETT_HALF      = BARRETT_SHIFT / 2;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int DEF_POINTS        = 4096;
    localparam int DEF_TWIDDLE_DEPTH = 4096;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_BITS         = $clog2(QUEUE_DEPTH);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_BFLY = 1'b1;

    localparam logic [SPAN_BITS-1:0]   RST_HALF_SPAN = 12'd1;
    localparam logic [SPAN_BITS-1:0]   RST_STRIDE    = 12'd1;
    localparam logic [SPAN_BITS-1:0]   RST_SCALE     = 12'd1;
    localparam logic [VALUE_BITS-1:0]  RST_MODULUS   = 12'd3329;
    localparam logic [FACTOR_BITS-1:0] RST_FACTOR    = 52'd1352829926;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_HALF_SPAN = 3'd0,
        REG_STRIDE    = 3'd1,
        REG_SCALE     = 3'd2,
        REG_MODULUS   = 3'd3,
        REG_FACTOR    = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [SPAN_BITS-1:0]   half_span;
        logic [SPAN_BITS-1:0]   stride;
        logic [SPAN_BITS-1:0]   scale;
        logic [VALUE_BITS-1:0]  modulus;
        logic [FACTOR_BITS-1:0] factor;
    } cfg_t;

    typedef struct packed {
        logic                  store;
        logic                  action;
        logic [ADDR_BITS-1:0]  tw_index;
        logic [VALUE_BITS-1:0] tw_value;
        logic [PAIR_BITS-1:0]  pair;
        logic [VALUE_BITS-1:0] first;
        logic [VALUE_BITS-1:0] second;
        logic                  sel;
    } bfly_item_t;

endpackage

@@ design/ntt_bfly_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ntt_bfly_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/ntt_bfly_rem.sv @@
// Pipelined restoring remainder unit, one quotient bit per stage, with a side tag.
// No dependencies.
module ntt_bfly_rem #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] divisor,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [TW-1:0] out_tag
);

    logic [NW-1:0] valid_reg;
    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [TW-1:0] tag_reg [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_step
        logic          valid_prev;
        logic [DW-1:0] rem_prev;
        logic [NW-1:0] num_prev;
        logic [TW-1:0] tag_prev;
        logic [DW:0]   trial;
        logic [DW:0]   trial_sub;
        logic [DW-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = '0;
            assign num_prev   = in_num;
            assign tag_prev   = in_tag;
        end
        else
        begin : g_rest
            assign valid_prev = valid_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign num_prev   = num_reg[k-1];
            assign tag_prev   = tag_reg[k-1];
        end

        assign trial     = {rem_prev, num_prev[NW-1]};
        assign trial_sub = trial - {1'b0, divisor};
        assign rem_next  = (trial >= {1'b0, divisor}) ? trial_sub[DW-1:0] : trial[DW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            num_reg[k] <= num_prev << 1;
            tag_reg[k] <= tag_prev;
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign out_rem   = rem_reg[NW-1];
    assign out_tag   = tag_reg[NW-1];

endmodule

@@ design/ntt_bfly_front.sv @@
// Front end: takes items, marks table loads that land in range, queues them.
// Depends on ntt_bfly_pkg.
module ntt_bfly_front
    import ntt_bfly_pkg::*;
#(
    parameter int TWIDDLE_DEPTH = DEF_TWIDDLE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  action,
    input  logic [ADDR_BITS-1:0]  twiddle_index,
    input  logic [VALUE_BITS-1:0] twiddle_value,
    input  logic [PAIR_BITS-1:0]  pair_index,
    input  logic [VALUE_BITS-1:0] first_value,
    input  logic [VALUE_BITS-1:0] second_value,
    input  logic                  target_buffer,
    output logic                  busy,
    output logic                  q_valid,
    output bfly_item_t            q_item
);

    bfly_item_t           queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;
    logic                 push;
    logic                 pop;
    bfly_item_t           item_new;

    assign busy    = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign pop     = q_valid;
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb
    begin
        item_new.store    = (action == ACT_LOAD) && (int'(twiddle_index) < TWIDDLE_DEPTH);
        item_new.action   = action;
        item_new.tw_index = twiddle_index;
        item_new.tw_value = twiddle_value;
        item_new.pair     = pair_index;
        item_new.first    = first_value;
        item_new.second   = second_value;
        item_new.sel      = target_buffer;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item_new;
        end
    end

endmodule

@@ design/ntt_bfly_back.sv @@
// Back end: index remainders, twiddle table, Barrett multiply, final mod p.
// Depends on ntt_bfly_pkg, ntt_bfly_rem and ntt_bfly_ram.
module ntt_bfly_back
    import ntt_bfly_pkg::*;
#(
    parameter int POINTS        = DEF_POINTS,
    parameter int TWIDDLE_DEPTH = DEF_TWIDDLE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    input  bfly_item_t            in_item,
    output logic                  done,
    output logic [ADDR_BITS-1:0]  sum_address,
    output logic [VALUE_BITS-1:0] sum_value,
    output logic [ADDR_BITS-1:0]  diff_address,
    output logic [VALUE_BITS-1:0] diff_value,
    output logic                  write_buffer
);

    localparam int TAW = $clog2(TWIDDLE_DEPTH);
    localparam int XW  = PAIR_BITS + 2 * SPAN_BITS;
    localparam int DW2 = 2 * VALUE_BITS;
    localparam int PPW = DW2 + BARRETT_HALF;
    localparam int QW  = PPW + 1 - BARRETT_HALF;
    localparam int QPW = QW + VALUE_BITS;
    localparam int RW  = QPW + 2;
    localparam int SW  = RW + 1;

    typedef struct packed {
        bfly_item_t             item;
        logic [ADDR_BITS-1:0]   u;
        logic [ADDR_BITS:0]     v;
    } ctx_d_t;

    typedef struct packed {
        logic                   sel;
        logic [VALUE_BITS-1:0]  first;
        logic [VALUE_BITS-1:0]  second;
        logic [ADDR_BITS-1:0]   saddr;
        logic [ADDR_BITS-1:0]   daddr;
    } ctx_t;

    typedef struct packed {
        ctx_t                   ctx;
        logic                   neg;
    } ctx_r_t;

    logic                  a_valid;
    logic [SPAN_BITS-1:0]  a_rem;
    bfly_item_t            a_item;

    ntt_bfly_rem #(.NW(PAIR_BITS), .DW(SPAN_BITS), .TW($bits(bfly_item_t))) u_rem_span (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_num(in_item.pair),
        .divisor(cfg.half_span), .in_tag(in_item),
        .out_valid(a_valid), .out_rem(a_rem), .out_tag(a_item)
    );

    logic                       b_valid_reg;
    bfly_item_t                 b_item_reg;
    logic [ADDR_BITS-1:0]       b_u_reg;
    logic [ADDR_BITS:0]         b_v_reg;
    logic [PAIR_BITS+SPAN_BITS-1:0] b_prod_reg;
    logic [ADDR_BITS-1:0]       b_u_next;

    assign b_u_next = ADDR_BITS'({a_item.pair, 1'b0}) - ADDR_BITS'(a_rem);

    logic          c_valid_reg;
    ctx_d_t        c_ctx_reg;
    logic [XW-1:0] c_x_reg;

    always_ff @(posedge clk)
    begin
        b_item_reg <= a_item;
        b_u_reg    <= b_u_next;
        b_v_reg    <= (ADDR_BITS+1)'(b_u_next) + (ADDR_BITS+1)'(cfg.half_span);
        b_prod_reg <= a_rem[PAIR_BITS-1:0] * cfg.stride;
        c_ctx_reg.item <= b_item_reg;
        c_ctx_reg.u    <= b_u_reg;
        c_ctx_reg.v    <= b_v_reg;
        c_x_reg        <= b_prod_reg * cfg.scale;
    end

    logic                  d_valid;
    logic [VALUE_BITS-1:0] d_rem;
    ctx_d_t                d_ctx;

    ntt_bfly_rem #(.NW(XW), .DW(VALUE_BITS), .TW($bits(ctx_d_t))) u_rem_exp (
        .clk(clk), .rst_n(rst_n), .in_valid(c_valid_reg), .in_num(c_x_reg),
        .divisor(cfg.modulus - 1'b1), .in_tag(c_ctx_reg),
        .out_valid(d_valid), .out_rem(d_rem), .out_tag(d_ctx)
    );

    logic [TAW-1:0]       g_taddr;
    logic [ADDR_BITS-1:0] g_saddr;
    logic [ADDR_BITS-1:0] g_daddr;

    assign g_taddr = TAW'(d_rem & VALUE_BITS'(TWIDDLE_DEPTH - 1));
    assign g_saddr = d_ctx.u & ADDR_BITS'(POINTS - 1);
    assign g_daddr = ADDR_BITS'(d_ctx.v & (ADDR_BITS+1)'(POINTS - 1));

    logic [VALUE_BITS-1:0] tw_rdata;

    ntt_bfly_ram #(.WIDTH(VALUE_BITS), .DEPTH(TWIDDLE_DEPTH)) u_twiddle_ram (
        .clk(clk),
        .we(d_valid && d_ctx.item.store),
        .waddr(TAW'(d_ctx.item.tw_index)),
        .wdata(d_ctx.item.tw_value),
        .raddr(g_taddr),
        .rdata(tw_rdata)
    );

    logic                  h_valid_reg;
    ctx_t                  h_ctx_reg;
    logic                  i_valid_reg;
    ctx_t                  i_ctx_reg;
    logic [DW2-1:0]        i_d_reg;
    logic                  j_valid_reg;
    ctx_t                  j_ctx_reg;
    logic [DW2-1:0]        j_d_reg;
    logic [PPW-1:0]        j_lo_reg;
    logic [PPW-1:0]        j_hi_reg;
    logic                  k_valid_reg;
    ctx_t                  k_ctx_reg;
    logic [DW2-1:0]        k_d_reg;
    logic [QW-1:0]         k_q_reg;
    logic                  l_valid_reg;
    ctx_t                  l_ctx_reg;
    logic [DW2-1:0]        l_d_reg;
    logic [QPW-1:0]        l_qp_reg;
    logic                  m_valid_reg;
    ctx_t                  m_ctx_reg;
    logic signed [RW-1:0]  m_r_reg;
    logic                  n_valid_reg;
    ctx_t                  n_ctx_reg;
    logic signed [RW-1:0]  n_r_reg;
    logic                  o_valid_reg;
    ctx_t                  o_ctx_reg;
    logic signed [RW-1:0]  o_r_reg;
    logic                  p_valid_reg;
    ctx_t                  p_ctx_reg;
    logic signed [SW-1:0]  p_sum_reg;
    logic signed [SW-1:0]  p_diff_reg;
    logic                  q_valid_reg;
    ctx_r_t                q_tag_reg;
    logic                  q_diff_neg_reg;
    logic [SW-1:0]         q_sum_mag_reg;
    logic [SW-1:0]         q_diff_mag_reg;

    logic signed [RW-1:0]  p_ext;
    logic [PPW:0]          q_wide;

    assign p_ext  = $signed({{(RW-VALUE_BITS){1'b0}}, cfg.modulus});
    assign q_wide = (PPW+1)'(j_hi_reg) + (PPW+1)'(j_lo_reg >> BARRETT_HALF);

    always_ff @(posedge clk)
    begin
        h_ctx_reg.sel    <= d_ctx.item.sel;
        h_ctx_reg.first  <= d_ctx.item.first;
        h_ctx_reg.second <= d_ctx.item.second;
        h_ctx_reg.saddr  <= g_saddr;
        h_ctx_reg.daddr  <= g_daddr;

        i_ctx_reg <= h_ctx_reg;
        i_d_reg   <= tw_rdata * h_ctx_reg.second;

        j_ctx_reg <= i_ctx_reg;
        j_d_reg   <= i_d_reg;
        j_lo_reg  <= i_d_reg * cfg.factor[BARRETT_HALF-1:0];
        j_hi_reg  <= i_d_reg * cfg.factor[FACTOR_BITS-1:BARRETT_HALF];

        k_ctx_reg <= j_ctx_reg;
        k_d_reg   <= j_d_reg;
        k_q_reg   <= QW'(q_wide >> BARRETT_HALF);

        l_ctx_reg <= k_ctx_reg;
        l_d_reg   <= k_d_reg;
        l_qp_reg  <= k_q_reg * cfg.modulus;

        m_ctx_reg <= l_ctx_reg;
        m_r_reg   <= $signed(RW'(l_d_reg)) - $signed(RW'(l_qp_reg));

        n_ctx_reg <= m_ctx_reg;
        n_r_reg   <= (m_r_reg >= p_ext) ? m_r_reg - p_ext : m_r_reg;

        o_ctx_reg <= n_ctx_reg;
        o_r_reg   <= (n_r_reg < 0) ? n_r_reg + p_ext : n_r_reg;

        p_ctx_reg  <= o_ctx_reg;
        p_sum_reg  <= $signed(SW'(o_ctx_reg.first)) + SW'(o_r_reg);
        p_diff_reg <= $signed(SW'(o_ctx_reg.first)) - SW'(o_r_reg);

        q_tag_reg.ctx  <= p_ctx_reg;
        q_tag_reg.neg  <= p_sum_reg[SW-1];
        q_diff_neg_reg <= p_diff_reg[SW-1];
        q_sum_mag_reg  <= p_sum_reg[SW-1] ? SW'(-p_sum_reg) : SW'(p_sum_reg);
        q_diff_mag_reg <= p_diff_reg[SW-1] ? SW'(-p_diff_reg) : SW'(p_diff_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
            l_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            n_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid;
            c_valid_reg <= b_valid_reg;
            h_valid_reg <= d_valid && (d_ctx.item.action == ACT_BFLY);
            i_valid_reg <= h_valid_reg;
            j_valid_reg <= i_valid_reg;
            k_valid_reg <= j_valid_reg;
            l_valid_reg <= k_valid_reg;
            m_valid_reg <= l_valid_reg;
            n_valid_reg <= m_valid_reg;
            o_valid_reg <= n_valid_reg;
            p_valid_reg <= o_valid_reg;
            q_valid_reg <= p_valid_reg;
        end
    end

    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_sum_rem;
    ctx_r_t                r_tag;
    logic                  r_diff_valid;
    logic [VALUE_BITS-1:0] r_diff_rem;
    logic                  r_diff_neg;

    ntt_bfly_rem #(.NW(SW), .DW(VALUE_BITS), .TW($bits(ctx_r_t))) u_rem_sum (
        .clk(clk), .rst_n(rst_n), .in_valid(q_valid_reg), .in_num(q_sum_mag_reg),
        .divisor(cfg.modulus), .in_tag(q_tag_reg),
        .out_valid(r_valid), .out_rem(r_sum_rem), .out_tag(r_tag)
    );

    ntt_bfly_rem #(.NW(SW), .DW(VALUE_BITS), .TW(1)) u_rem_diff (
        .clk(clk), .rst_n(rst_n), .in_valid(q_valid_reg), .in_num(q_diff_mag_reg),
        .divisor(cfg.modulus), .in_tag(q_diff_neg_reg),
        .out_valid(r_diff_valid), .out_rem(r_diff_rem), .out_tag(r_diff_neg)
    );

    logic                  done_reg;
    logic [ADDR_BITS-1:0]  sum_address_reg;
    logic [VALUE_BITS-1:0] sum_value_reg;
    logic [ADDR_BITS-1:0]  diff_address_reg;
    logic [VALUE_BITS-1:0] diff_value_reg;
    logic                  write_buffer_reg;
    logic                  small_mod;

    assign small_mod = (cfg.modulus < VALUE_BITS'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= r_valid && r_diff_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_address_reg  <= r_tag.ctx.saddr;
        diff_address_reg <= r_tag.ctx.daddr;
        write_buffer_reg <= r_tag.ctx.sel;
        if (small_mod)
        begin
            sum_value_reg  <= '0;
            diff_value_reg <= '0;
        end
        else
        begin
            sum_value_reg  <= (r_tag.neg && r_sum_rem != '0) ?
                              cfg.modulus - r_sum_rem : r_sum_rem;
            diff_value_reg <= (r_diff_neg && r_diff_rem != '0) ?
                              cfg.modulus - r_diff_rem : r_diff_rem;
        end
    end

    assign done         = done_reg;
    assign sum_address  = sum_address_reg;
    assign sum_value    = sum_value_reg;
    assign diff_address = diff_address_reg;
    assign diff_value   = diff_value_reg;
    assign write_buffer = write_buffer_reg;

endmodule

@@ design/ntt_stockham_butterfly_barrett_core.sv @@
// Top level of the radix-2 Stockham NTT butterfly core with Barrett reduction.
// Depends on ntt_bfly_pkg, ntt_bfly_front and ntt_bfly_back.
//
// Usage:
//   Configuration: cfg_write, cfg_index, cfg_data write one register per cycle:
//   half span, twiddle stride, twiddle scale, modulus, Barrett factor.
//   Input: an item transfers on a clock edge with start high and busy low.
//   action low loads one twiddle word; action high runs one butterfly.
//   Output: each butterfly gives one result, shown for one cycle with done high.
//   Loads give no result.
//   Throughput: one item per cycle; busy stays low in steady operation.
//   Path: from the transfer edge to done high, an item passes the bit-serial
//   remainder pipelines for span and exponent, the table read, the Barrett
//   multiply stages and the bit-serial remainder pipelines for the final mod p.
//   Reset: clears the queue, all pipeline valids and done; configuration
//   returns to its defaults; the twiddle table holds no defined value until
//   loaded.
//   The receiver cannot stall: every result is taken in the cycle it is shown.
module ntt_stockham_butterfly_barrett_core
    import ntt_bfly_pkg::*;
#(
    parameter int POINTS        = DEF_POINTS,
    parameter int TWIDDLE_DEPTH = DEF_TWIDDLE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FACTOR_BITS-1:0]    cfg_data,
    input  logic                      start,
    output logic                      busy,
    input  logic                      action,
    input  logic [ADDR_BITS-1:0]      twiddle_index,
    input  logic [VALUE_BITS-1:0]     twiddle_value,
    input  logic [PAIR_BITS-1:0]      pair_index,
    input  logic [VALUE_BITS-1:0]     first_value,
    input  logic [VALUE_BITS-1:0]     second_value,
    input  logic                      target_buffer,
    output logic                      done,
    output logic [ADDR_BITS-1:0]      sum_address,
    output logic [VALUE_BITS-1:0]     sum_value,
    output logic [ADDR_BITS-1:0]      diff_address,
    output logic [VALUE_BITS-1:0]     diff_value,
    output logic                      write_buffer
);

    cfg_t       cfg_reg;
    logic       q_valid;
    bfly_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_span <= RST_HALF_SPAN;
            cfg_reg.stride    <= RST_STRIDE;
            cfg_reg.scale     <= RST_SCALE;
            cfg_reg.modulus   <= RST_MODULUS;
            cfg_reg.factor    <= RST_FACTOR;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HALF_SPAN: cfg_reg.half_span <= cfg_data[SPAN_BITS-1:0];
                REG_STRIDE:    cfg_reg.stride    <= cfg_data[SPAN_BITS-1:0];
                REG_SCALE:     cfg_reg.scale     <= cfg_data[SPAN_BITS-1:0];
                REG_MODULUS:   cfg_reg.modulus   <= cfg_data[VALUE_BITS-1:0];
                REG_FACTOR:    cfg_reg.factor    <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    ntt_bfly_front #(.TWIDDLE_DEPTH(TWIDDLE_DEPTH)) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .action(action),
        .twiddle_index(twiddle_index),
        .twiddle_value(twiddle_value),
        .pair_index(pair_index),
        .first_value(first_value),
        .second_value(second_value),
        .target_buffer(target_buffer),
        .busy(busy),
        .q_valid(q_valid),
        .q_item(q_item)
    );

    ntt_bfly_back #(.POINTS(POINTS), .TWIDDLE_DEPTH(TWIDDLE_DEPTH)) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .in_valid(q_valid),
        .in_item(q_item),
        .done(done),
        .sum_address(sum_address),
        .sum_value(sum_value),
        .diff_address(diff_address),
        .diff_value(diff_value),
        .write_buffer(write_buffer)
    );

endmodule

@@ design/ntt_bfly_checker.sv @@
// Port-level checker for the butterfly core, with its bind statement.
// Depends on ntt_bfly_pkg and the top level.
module ntt_bfly_checker
    import ntt_bfly_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  busy,
    input logic                  done,
    input logic [VALUE_BITS-1:0] sum_value,
    input logic [VALUE_BITS-1:0] diff_value
);

    assert property (@(posedge clk) !rst_n |-> !done && !busy)
        else $error("done or busy active during reset");

    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("queue filled while back end drains every cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sum_value != '1) && (diff_value != '1))
        else $error("result value not reduced below modulus range");

endmodule

bind ntt_stockham_butterfly_barrett_core ntt_bfly_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .busy(busy),
    .done(done),
    .sum_value(sum_value),
    .diff_value(diff_value)
);

@@ tb/sv/tb_ntt_stockham_butterfly_barrett_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the Stockham NTT butterfly core with Barrett reduction.
// Depends on ntt_bfly_pkg and ntt_stockham_butterfly_barrett_core.
module tb_ntt_stockham_butterfly_barrett_core;
    import ntt_bfly_pkg::*;

    localparam int PIPE_DRAIN = 150;

    typedef struct {
        logic                  act;
        logic [ADDR_BITS-1:0]  tw_idx;
        logic [VALUE_BITS-1:0] tw_val;
        logic [PAIR_BITS-1:0]  pair;
        logic [VALUE_BITS-1:0] c_val;
        logic [VALUE_BITS-1:0] s_val;
        logic                  buf_sel;
    } bfly_req_t;

    typedef struct {
        logic [ADDR_BITS-1:0]  sum_addr;
        logic [VALUE_BITS-1:0] sum_val;
        logic [ADDR_BITS-1:0]  diff_addr;
        logic [VALUE_BITS-1:0] diff_val;
        logic                  wbuf;
    } bfly_res_t;

    typedef struct {
        bfly_req_t req;
        bit        typed;
        bfly_res_t res;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [FACTOR_BITS-1:0]    cfg_data;
    logic                      start;
    logic                      busy;
    logic                      action;
    logic [ADDR_BITS-1:0]      twiddle_index;
    logic [VALUE_BITS-1:0]     twiddle_value;
    logic [PAIR_BITS-1:0]      pair_index;
    logic [VALUE_BITS-1:0]     first_value;
    logic [VALUE_BITS-1:0]     second_value;
    logic                      target_buffer;
    logic                      done;
    logic [ADDR_BITS-1:0]      sum_address;
    logic [VALUE_BITS-1:0]     sum_value;
    logic [ADDR_BITS-1:0]      diff_address;
    logic [VALUE_BITS-1:0]     diff_value;
    logic                      write_buffer;

    ntt_stockham_butterfly_barrett_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .twiddle_index(twiddle_index),
        .twiddle_value(twiddle_value),
        .pair_index   (pair_index),
        .first_value  (first_value),
        .second_value (second_value),
        .target_buffer(target_buffer),
        .done         (done),
        .sum_address  (sum_address),
        .sum_value    (sum_value),
        .diff_address (diff_address),
        .diff_value   (diff_value),
        .write_buffer (write_buffer)
    );

    cfg_t                  mdl_cfg;
    bit [VALUE_BITS-1:0]   tw_mem[DEF_TWIDDLE_DEPTH];
    bit                    tw_known[DEF_TWIDDLE_DEPTH];
    bfly_res_t             pending_bflys[$];
    int                    mismatches;
    bit                    gaps_on;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint unsigned span_mod(logic [PAIR_BITS-1:0] j);
        if (mdl_cfg.half_span == 0)
            return j;
        return j % mdl_cfg.half_span;
    endfunction

    function automatic int twiddle_slot(logic [PAIR_BITS-1:0] j);
        longint unsigned e;
        e = span_mod(j) * mdl_cfg.stride * mdl_cfg.scale;
        return int'((e % (mdl_cfg.modulus - 1)) % DEF_TWIDDLE_DEPTH);
    endfunction

    function automatic bfly_res_t butterfly_result(bfly_req_t rq);
        bfly_res_t        o;
        longint unsigned  jm, base, d;
        bit [127:0]       prod;
        longint           q, p, r, sm, df;
        jm = span_mod(rq.pair);
        sm = 0;
        df = 0;
        if (mdl_cfg.modulus >= 2)
        begin
            d = longint'(tw_mem[twiddle_slot(rq.pair)]) * rq.s_val;
            prod = 128'(d) * 128'(mdl_cfg.factor);
            q = longint'(prod >> BARRETT_SHIFT);
            p = mdl_cfg.modulus;
            r = longint'(d) - q * p;
            if (r >= p)
                r -= p;
            if (r < 0)
                r += p;
            sm = (longint'(rq.c_val) + r) % p;
            if (sm < 0)
                sm += p;
            df = (longint'(rq.c_val) - r) % p;
            if (df < 0)
                df += p;
        end
        base = (2 * longint'(rq.pair) - jm) % DEF_POINTS;
        o.sum_addr  = base[ADDR_BITS-1:0];
        o.sum_val   = sm[VALUE_BITS-1:0];
        o.diff_addr = ADDR_BITS'((base + mdl_cfg.half_span) % DEF_POINTS);
        o.diff_val  = df[VALUE_BITS-1:0];
        o.wbuf      = rq.buf_sel;
        return o;
    endfunction

    // Present one item, hold until transfer, then update the model.
    task automatic send_item(bfly_req_t rq, bit typed, bfly_res_t tres);
        int gap;
        start         <= 1'b1;
        action        <= rq.act;
        twiddle_index <= rq.tw_idx;
        twiddle_value <= rq.tw_val;
        pair_index    <= rq.pair;
        first_value   <= rq.c_val;
        second_value  <= rq.s_val;
        target_buffer <= rq.buf_sel;
        do
            @(posedge clk);
        while (busy);
        if (rq.act == ACT_LOAD)
        begin
            tw_mem[rq.tw_idx]   = rq.tw_val;
            tw_known[rq.tw_idx] = 1'b1;
        end
        else
            pending_bflys.push_back(typed ? tres : butterfly_result(rq));
        gap = 0;
        if (gaps_on)
        begin
            gap = $urandom_range(0, 99);
            gap = (gap < 55) ? 0 : (gap < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_checked(bfly_req_t rq);
        bfly_res_t unused;
        unused = '{default: '0};
        send_item(rq, 1'b0, unused);
    endtask

    // Drain the pipe, then write all registers back to back.
    task automatic write_config(cfg_t nc);
        logic [FACTOR_BITS-1:0] vals[5];
        reg_index_t             idx[5];
        idx  = '{REG_HALF_SPAN, REG_STRIDE, REG_SCALE, REG_MODULUS, REG_FACTOR};
        vals = '{52'(nc.half_span), 52'(nc.stride), 52'(nc.scale), 52'(nc.modulus),
                 nc.factor};
        start <= 1'b0;
        @(posedge clk);
        while (pending_bflys.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        mdl_cfg = nc;
    endtask

    always @(posedge clk)
    begin
        bfly_res_t e;
        if (rst_n && done)
        begin
            if (pending_bflys.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: sum %0d@%0d diff %0d@%0d",
                             sum_value, sum_address, diff_value, diff_address);
            end
            else
            begin
                e = pending_bflys.pop_front();
                if (sum_address !== e.sum_addr || sum_value !== e.sum_val ||
                    diff_address !== e.diff_addr || diff_value !== e.diff_val ||
                    write_buffer !== e.wbuf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                                 e.sum_addr, e.sum_val, e.diff_addr, e.diff_val, e.wbuf,
                                 sum_address, sum_value, diff_address, diff_value,
                                 write_buffer);
                end
            end
        end
    end

    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        stim_row_t  dir_rows[$];
        cfg_t       phases[$];
        cfg_t       nc;
        bfly_req_t  rq;
        int         sent;
        int         slot;

        mismatches    = 0;
        gaps_on       = 1'b0;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        start         = 1'b0;
        action        = ACT_LOAD;
        twiddle_index = '0;
        twiddle_value = '0;
        pair_index    = '0;
        first_value   = '0;
        second_value  = '0;
        target_buffer = 1'b0;
        mdl_cfg = '{RST_HALF_SPAN, RST_STRIDE, RST_SCALE, RST_MODULUS, RST_FACTOR};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: span one keeps every butterfly on twiddle slot zero.
        dir_rows = '{
            '{'{ACT_LOAD, 12'd0, 12'd1, 11'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '{default: '0}},
            '{'{ACT_LOAD, 12'd4095, 12'd4095, 11'd0, 12'd0, 12'd0, 1'b0}, 1'b0,
              '{default: '0}},
            '{'{ACT_BFLY, 12'd0, 12'd0, 11'd0, 12'd5, 12'd7, 1'b0}, 1'b1,
              '{12'd0, 12'd12, 12'd1, 12'd3327, 1'b0}},
            '{'{ACT_BFLY, 12'd0, 12'd0, 11'd2047, 12'd4095, 12'd0, 1'b1}, 1'b1,
              '{12'd4094, 12'd766, 12'd4095, 12'd766, 1'b1}},
            '{'{ACT_BFLY, 12'hFFF, 12'hFFF, 11'd1365, 12'd3328, 12'd3328, 1'b1}, 1'b0,
              '{default: '0}},
            '{'{ACT_LOAD, 12'd0, 12'd3328, 11'd0, 12'd0, 12'd0, 1'b0}, 1'b0,
              '{default: '0}},
            '{'{ACT_BFLY, 12'd0, 12'd0, 11'd682, 12'd0, 12'd4095, 1'b0}, 1'b0,
              '{default: '0}},
            '{'{ACT_BFLY, 12'd0, 12'd0, 11'd1, 12'd2730, 12'd1365, 1'b1}, 1'b0,
              '{default: '0}},
            '{'{ACT_LOAD, 12'd2730, 12'd2730, 11'd0, 12'd0, 12'd0, 1'b1}, 1'b0,
              '{default: '0}},
            '{'{ACT_LOAD, 12'd1365, 12'd1365, 11'd0, 12'd0, 12'd0, 1'b0}, 1'b0,
              '{default: '0}}
        };
        foreach (dir_rows[i])
            send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

        phases = '{
            '{RST_HALF_SPAN, RST_STRIDE, RST_SCALE, RST_MODULUS, RST_FACTOR},
            '{12'd0, 12'd1, 12'd1, 12'd3329, 52'd1352829926},
            '{12'd2048, 12'd2048, 12'd4095, 12'd4095, 52'd0},
            '{12'd4095, 12'd0, 12'd0, 12'd0, 52'hF_FFFF_FFFF_FFFF},
            '{12'd16, 12'd3, 12'd13, 12'd1, 52'd12345},
            '{12'd1, 12'd2048, 12'd4095, 12'd2, 52'hF_FFFF_FFFF_FFFF},
            '{12'd8, 12'd5, 12'd3, 12'd17, 52'd264917625139440},
            '{12'd64, 12'd7, 12'd1, 12'd3329, 52'd1352829926}
        };
        for (int k = 0; k < 4; k++)
        begin
            nc.half_span = 12'($urandom_range(1, 2048));
            nc.stride    = 12'($urandom_range(0, 2048));
            nc.scale     = 12'($urandom);
            nc.modulus   = 12'($urandom_range(2, 4095));
            nc.factor    = (k < 2) ? 52'((64'd1 << 52) / nc.modulus) :
                           52'({$urandom, $urandom} & 64'hF_FFFF_FFFF_FFFF);
            phases.push_back(nc);
        end

        foreach (phases[ph])
        begin
            write_config(phases[ph]);
            gaps_on = (ph % 3) != 1;
            sent = 0;
            while (sent < 42)
            begin
                rq.act     = ($urandom_range(0, 9) < 7) ? ACT_BFLY : ACT_LOAD;
                rq.tw_idx  = 12'($urandom);
                rq.tw_val  = 12'($urandom);
                rq.pair    = 11'($urandom);
                rq.c_val   = ($urandom_range(0, 3) == 0) ? 12'($urandom) :
                             12'($urandom_range(0, (mdl_cfg.modulus > 0) ?
                                                mdl_cfg.modulus - 1 : 0));
                rq.s_val   = 12'($urandom);
                rq.buf_sel = 1'($urandom);
                if (rq.act == ACT_BFLY && mdl_cfg.modulus >= 2)
                begin
                    slot = twiddle_slot(rq.pair);
                    if (!tw_known[slot])
                    begin
                        bfly_req_t ld;
                        ld        = rq;
                        ld.act    = ACT_LOAD;
                        ld.tw_idx = 12'(slot);
                        send_checked(ld);
                    end
                end
                send_checked(rq);
                sent++;
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_bflys.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
